[design/gprd_pkg.sv]
// shared types, codes and helpers for the gamepad report decoder
package gprd_pkg;

    // event codes on the action field
    localparam logic [1:0] ACT_REPORT     = 2'd0;
    localparam logic [1:0] ACT_CONNECT    = 2'd1;
    localparam logic [1:0] ACT_DISCONNECT = 2'd2;

    // report type bytes
    localparam logic [7:0] RID_PRO      = 8'h3D;
    localparam logic [7:0] RID_EXT      = 8'h34;
    localparam logic [7:0] RID_BUTTONS  = 8'h30;
    localparam logic [7:0] RID_STATUS   = 8'h20;
    localparam logic [7:0] RID_ACK      = 8'h22;
    localparam logic [7:0] RID_READ     = 8'h21;

    // identity word returned by the extension read
    localparam logic [31:0] IDENT_WORD = 32'hA420_0101;

    // pad actions
    localparam logic [1:0] PAD_NONE   = 2'd0;
    localparam logic [1:0] PAD_WRITE  = 2'd1;
    localparam logic [1:0] PAD_UNUSED = 2'd2;

    // controller kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_PRO   = 2'd1;
    localparam logic [1:0] KIND_PLAIN = 2'd2;

    // outgoing message codes
    localparam logic [2:0] MSG_NONE         = 3'd0;
    localparam logic [2:0] MSG_LEDS         = 3'd1;
    localparam logic [2:0] MSG_STATUS_MODE  = 3'd2;
    localparam logic [2:0] MSG_STATUS_REQ   = 3'd3;
    localparam logic [2:0] MSG_INIT_WRITE   = 3'd4;
    localparam logic [2:0] MSG_UNLOCK_WRITE = 3'd5;
    localparam logic [2:0] MSG_IDENT_READ   = 3'd6;
    localparam logic [2:0] MSG_STREAM_MODE  = 3'd7;

    // result queue sizing
    localparam int RES_PTR_W = 2;
    localparam int RES_DEPTH = 1 << RES_PTR_W;

    // extension set-up phases
    typedef enum logic [2:0] {
        PH_DONE      = 3'd0,
        PH_EXT1      = 3'd1,
        PH_EXT2      = 3'd2,
        PH_CONNECT   = 3'd3,
        PH_SET_IDENT = 3'd4,
        PH_GET_IDENT = 3'd5
    } t_phase;

    // one result item
    typedef struct packed {
        logic [1:0]         pad_action;
        logic [1:0]         pad_kind;
        logic signed [13:0] stick_left_x;
        logic signed [13:0] stick_right_x;
        logic signed [13:0] stick_left_y;
        logic signed [13:0] stick_right_y;
        logic [15:0]        buttons;
        logic [7:0]         trigger_left;
        logic [7:0]         trigger_right;
        logic               trigger_valid;
        logic [2:0]         message;
        logic               last;
    } t_result;

    // decode outcome for one event
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
        t_phase     phase;
        logic [1:0] kind;
    } t_dec;

    // result that carries only a pad action and a message
    function automatic t_result msg_res(input logic [1:0] pa, input logic [2:0] msg);
        t_result r;
        r            = '0;
        r.pad_action = pa;
        r.message    = msg;
        return r;
    endfunction

endpackage

[design/gprd_decode.sv]
// event decode: handshake steps and report field unpacking
module gprd_decode (
    input  logic [1:0]     i_action,
    input  logic [7:0]     i_report_id,
    input  logic [63:0]    i_report_head,
    input  logic [31:0]    i_report_tail,
    input  logic           i_channel_assigned,
    input  logic           i_report_mode,
    input  gprd_pkg::t_phase i_phase,
    input  logic [1:0]     i_kind,
    output gprd_pkg::t_dec o_dec
);
    import gprd_pkg::*;

    logic [7:0]  b [1:12];
    logic [4:0]  ext_ly;
    logic [31:0] ident;
    t_result     pad;

    // split report into bytes, byte 1 first
    always_comb begin
        for (int k = 1; k <= 8; k++) begin
            b[k] = i_report_head[8*(8-k) +: 8];
        end
        for (int k = 9; k <= 12; k++) begin
            b[k] = i_report_tail[8*(12-k) +: 8];
        end
    end

    assign ext_ly = {b[3][7:6], b[4][7:6], b[5][7]};
    assign ident  = {b[8], b[9], b[10], b[11]};

    // pad fields for the two axis report formats
    always_comb begin
        pad            = '0;
        pad.pad_action = PAD_WRITE;
        if (i_report_id == RID_PRO) begin
            pad.pad_kind      = KIND_PRO;
            pad.stick_left_x  = 14'({b[2], b[1]} >> 3) - 14'sd256;
            pad.stick_right_x = 14'({b[4], b[3]} >> 3) - 14'sd256;
            pad.stick_left_y  = 14'({b[6], b[5]} >> 3) - 14'sd256;
            pad.stick_right_y = 14'({b[8], b[7]} >> 3) - 14'sd256;
            pad.buttons       = ~{b[9], b[10]};
        end else begin
            pad.pad_kind      = i_kind;
            pad.stick_left_x  = 14'({b[3][5:0], 2'b00}) - 14'sd126;
            pad.stick_right_x = 14'({ext_ly, 3'b000}) - 14'sd124;
            pad.stick_left_y  = 14'({b[4][5:0], 2'b00}) - 14'sd126;
            pad.stick_right_y = 14'({b[5][4:0], 3'b000}) - 14'sd124;
            pad.buttons       = ~{b[7][7:1], 1'b0, b[8]};
            if (i_kind == KIND_PLAIN) begin
                pad.trigger_left  = {b[5][6:5], b[6][7:5], 3'b000};
                pad.trigger_right = {b[6][4:0], 3'b000};
                pad.trigger_valid = 1'b1;
            end
        end
    end

    // handshake steps and result selection
    always_comb begin
        o_dec       = '0;
        o_dec.phase = i_phase;
        o_dec.kind  = i_kind;
        case (i_action)
            ACT_CONNECT: begin
                o_dec.count = 2'd2;
                o_dec.res0  = msg_res(PAD_NONE, MSG_LEDS);
                if (!i_report_mode) begin
                    o_dec.res1  = msg_res(PAD_NONE, MSG_STATUS_MODE);
                    o_dec.phase = PH_CONNECT;
                    o_dec.kind  = KIND_NONE;
                end else begin
                    o_dec.res1  = msg_res(PAD_NONE, MSG_STREAM_MODE);
                    o_dec.phase = PH_DONE;
                    o_dec.kind  = KIND_PRO;
                end
            end
            ACT_DISCONNECT: begin
                if (i_channel_assigned) begin
                    o_dec.count = 2'd1;
                    o_dec.res0  = msg_res(PAD_UNUSED, MSG_NONE);
                end
            end
            ACT_REPORT: begin
                if (i_report_id == RID_PRO) begin
                    if (i_channel_assigned) begin
                        o_dec.count = 2'd1;
                        o_dec.res0  = pad;
                    end
                end else if (i_report_id == RID_EXT) begin
                    if (i_channel_assigned && i_kind != KIND_NONE) begin
                        o_dec.count = 2'd1;
                        o_dec.res0  = pad;
                    end
                end else if (i_report_id == RID_BUTTONS) begin
                    if (i_phase == PH_CONNECT) begin
                        o_dec.count = 2'd1;
                        o_dec.res0  = msg_res(PAD_NONE, MSG_STATUS_REQ);
                        o_dec.phase = PH_EXT1;
                    end
                end else if (i_report_id == RID_STATUS || i_report_id == RID_ACK) begin
                    if (b[3][1]) begin
                        if (i_report_id == RID_STATUS && i_phase == PH_EXT1) begin
                            o_dec.count = 2'd1;
                            o_dec.res0  = msg_res(PAD_NONE, MSG_INIT_WRITE);
                            o_dec.phase = PH_EXT2;
                        end else if (i_report_id == RID_ACK && i_phase == PH_EXT2) begin
                            o_dec.count = 2'd1;
                            o_dec.res0  = msg_res(PAD_NONE, MSG_UNLOCK_WRITE);
                            o_dec.phase = PH_SET_IDENT;
                        end else if (i_report_id == RID_ACK && i_phase == PH_SET_IDENT) begin
                            o_dec.count = 2'd1;
                            o_dec.res0  = msg_res(PAD_NONE, MSG_IDENT_READ);
                            o_dec.phase = PH_GET_IDENT;
                        end
                    end else if (!i_report_mode) begin
                        // extension gone: restart the handshake
                        o_dec.kind  = KIND_NONE;
                        o_dec.phase = PH_EXT1;
                        if (i_channel_assigned) begin
                            o_dec.count = 2'd1;
                            o_dec.res0  = msg_res(PAD_UNUSED, MSG_NONE);
                        end
                    end
                end else if (i_report_id == RID_READ) begin
                    if (i_phase == PH_GET_IDENT) begin
                        if (ident == IDENT_WORD) begin
                            o_dec.kind  = (b[6] == 8'd0) ? KIND_PLAIN : KIND_PRO;
                            o_dec.count = 2'd1;
                            o_dec.res0  = msg_res(PAD_NONE, MSG_STREAM_MODE);
                        end
                        o_dec.phase = PH_DONE;
                    end
                end
            end
            default: begin
                o_dec.count = 2'd0;
            end
        endcase
        // flag the final result of the event
        if (o_dec.count == 2'd1) begin
            o_dec.res0.last = 1'b1;
        end
        if (o_dec.count == 2'd2) begin
            o_dec.res1.last = 1'b1;
        end
    end

endmodule

[design/gamepad_report_decoder_unit.sv]
// top level of the gamepad report decoder: input stage, state and result queue
//
// Input channel i_valid/o_ready carries one link event (connect, disconnect or
// received report). Output channel o_valid/i_ready carries result items; an
// event makes zero, one or two of them, the final one flagged by o_last.
// The configuration channel i_cfg_valid/o_cfg_ready writes report_mode; it is
// always ready. It must be written only while the block is idle; the block
// itself does not enforce this. An event is registered on acceptance and
// decoded from that register; its results enter the queue when the input
// stage advances, and the first result is offered from the queue head.
// Throughput: one event per cycle while each event gives at most one result
// and the receiver takes each one; the output drains one result per cycle
// while i_ready is high, so a connect event's two results leave in turn. A
// four-entry result queue sits between the decode and the output; the input
// stage advances while the queue has room for two results, so a stalled
// receiver backs up into o_ready after the queue fills, and nothing is lost.
// Reset (synchronous, active low) empties the input stage and the queue,
// sets the set-up phase to done, the controller kind to none and report_mode
// to zero.
module gamepad_report_decoder_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_action,
    input  logic [7:0]         i_report_id,
    input  logic [63:0]        i_report_head,
    input  logic [31:0]        i_report_tail,
    input  logic               i_channel_assigned,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_pad_action,
    output logic [1:0]         o_pad_kind,
    output logic signed [13:0] o_stick_left_x,
    output logic signed [13:0] o_stick_right_x,
    output logic signed [13:0] o_stick_left_y,
    output logic signed [13:0] o_stick_right_y,
    output logic [15:0]        o_buttons,
    output logic [7:0]         o_trigger_left,
    output logic [7:0]         o_trigger_right,
    output logic               o_trigger_valid,
    output logic [2:0]         o_message,
    output logic               o_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_report_mode
);
    import gprd_pkg::*;

    logic                 r_in_valid;
    logic [1:0]           r_action;
    logic [7:0]           r_report_id;
    logic [63:0]          r_report_head;
    logic [31:0]          r_report_tail;
    logic                 r_channel_assigned;
    logic                 r_report_mode;
    t_phase               r_phase;
    logic [1:0]           r_kind;
    t_result              r_queue [RES_DEPTH];
    logic [RES_PTR_W-1:0] r_wr_ptr;
    logic [RES_PTR_W-1:0] r_rd_ptr;
    logic [RES_PTR_W:0]   r_count;
    logic [RES_PTR_W:0]   n_count;
    logic                 room;
    logic                 advance;
    logic                 pop;
    logic [1:0]           push_n;
    t_dec                 dec;
    t_result              head;

    assign o_cfg_ready = 1'b1;

    // room for the largest event in the queue
    assign room    = r_count <= (RES_PTR_W + 1)'(RES_DEPTH - 2);
    assign advance = r_in_valid && room;
    assign o_ready = !r_in_valid || room;
    assign pop     = o_valid && i_ready;
    assign push_n  = advance ? dec.count : 2'd0;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_action           <= i_action;
            r_report_id        <= i_report_id;
            r_report_head      <= i_report_head;
            r_report_tail      <= i_report_tail;
            r_channel_assigned <= i_channel_assigned;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_report_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_report_mode <= i_cfg_report_mode;
        end
    end

    gprd_decode u_decode (
        .i_action           (r_action),
        .i_report_id        (r_report_id),
        .i_report_head      (r_report_head),
        .i_report_tail      (r_report_tail),
        .i_channel_assigned (r_channel_assigned),
        .i_report_mode      (r_report_mode),
        .i_phase            (r_phase),
        .i_kind             (r_kind),
        .o_dec              (dec)
    );

    // link state updates as each event leaves the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DONE;
            r_kind  <= KIND_NONE;
        end else if (advance) begin
            r_phase <= dec.phase;
            r_kind  <= dec.kind;
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_queue[r_wr_ptr] <= dec.res0;
        end
        if (push_n == 2'd2) begin
            r_queue[r_wr_ptr + RES_PTR_W'(1)] <= dec.res1;
        end
    end

    // queue pointers and fill count
    always_comb begin
        n_count = r_count + (RES_PTR_W + 1)'(push_n) - (RES_PTR_W + 1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + RES_PTR_W'(push_n);
            r_rd_ptr <= r_rd_ptr + RES_PTR_W'(pop);
            r_count  <= n_count;
        end
    end

    // output side
    assign o_valid         = r_count != '0;
    assign head            = r_queue[r_rd_ptr];
    assign o_pad_action    = head.pad_action;
    assign o_pad_kind      = head.pad_kind;
    assign o_stick_left_x  = head.stick_left_x;
    assign o_stick_right_x = head.stick_right_x;
    assign o_stick_left_y  = head.stick_left_y;
    assign o_stick_right_y = head.stick_right_y;
    assign o_buttons       = head.buttons;
    assign o_trigger_left  = head.trigger_left;
    assign o_trigger_right = head.trigger_right;
    assign o_trigger_valid = head.trigger_valid;
    assign o_message       = head.message;
    assign o_last          = head.last;

endmodule

[design/gprd_checker.sv]
// port-level checks for the gamepad report decoder, bound to the top level
module gprd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_cfg_ready,
    input logic [1:0]  o_pad_action,
    input logic [1:0]  o_pad_kind,
    input logic [15:0] o_buttons,
    input logic        o_trigger_valid,
    input logic [2:0]  o_message
);
    import gprd_pkg::*;

    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // nothing is offered right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered after reset");

    // every result carries a pad change or a message
    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pad_action != PAD_NONE || o_message != MSG_NONE))
        else $error("empty result");

    // only pad writes carry pad data
    a_pad_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pad_action != PAD_WRITE |->
            o_pad_kind == KIND_NONE && o_buttons == 16'd0 && !o_trigger_valid)
        else $error("pad data on a non-write result");

    // pad writes carry no message
    a_write_no_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pad_action == PAD_WRITE |-> o_message == MSG_NONE && o_cfg_ready)
        else $error("message on a pad write");

endmodule

bind gamepad_report_decoder_unit gprd_checker u_gprd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_cfg_ready     (o_cfg_ready),
    .o_pad_action    (o_pad_action),
    .o_pad_kind      (o_pad_kind),
    .o_buttons       (o_buttons),
    .o_trigger_valid (o_trigger_valid),
    .o_message       (o_message)
);

[sim/tb_gamepad_report_decoder_unit.sv]
// testbench for the gamepad report decoder: directed and random link events checked against a local decode
module tb_gamepad_report_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import gprd_pkg::*;

    localparam int HOLD_CYCLES  = 60;
    localparam int SETTLE_TICKS = 4;
    localparam int QUIET_LIMIT  = 2000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_action;
    logic [7:0]         i_report_id;
    logic [63:0]        i_report_head;
    logic [31:0]        i_report_tail;
    logic               i_channel_assigned;
    logic               o_valid;
    logic               i_ready;
    logic [1:0]         o_pad_action;
    logic [1:0]         o_pad_kind;
    logic signed [13:0] o_stick_left_x;
    logic signed [13:0] o_stick_right_x;
    logic signed [13:0] o_stick_left_y;
    logic signed [13:0] o_stick_right_y;
    logic [15:0]        o_buttons;
    logic [7:0]         o_trigger_left;
    logic [7:0]         o_trigger_right;
    logic               o_trigger_valid;
    logic [2:0]         o_message;
    logic               o_last;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_report_mode;

    // link state as the decoder should hold it
    logic       mode_shadow = 1'b0;
    t_phase     link_phase  = PH_DONE;
    logic [1:0] link_kind   = KIND_NONE;

    t_result pending_results[$];
    int      fail_count      = 0;
    int      quiet_cycles    = 0;
    bit      sender_gaps_on  = 1'b1;
    bit      ready_stalls_on = 1'b1;
    bit      hold_request    = 1'b0;

    gamepad_report_decoder_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_action           (i_action),
        .i_report_id        (i_report_id),
        .i_report_head      (i_report_head),
        .i_report_tail      (i_report_tail),
        .i_channel_assigned (i_channel_assigned),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_pad_action       (o_pad_action),
        .o_pad_kind         (o_pad_kind),
        .o_stick_left_x     (o_stick_left_x),
        .o_stick_right_x    (o_stick_right_x),
        .o_stick_left_y     (o_stick_left_y),
        .o_stick_right_y    (o_stick_right_y),
        .o_buttons          (o_buttons),
        .o_trigger_left     (o_trigger_left),
        .o_trigger_right    (o_trigger_right),
        .o_trigger_valid    (o_trigger_valid),
        .o_message          (o_message),
        .o_last             (o_last),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_report_mode  (i_cfg_report_mode)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result item that only carries a pad action and a message
    function automatic t_result control_item(input logic [1:0] pa, input logic [2:0] msg);
        t_result r;
        r            = '0;
        r.pad_action = pa;
        r.message    = msg;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // work out the results of one link event and advance the link state
    task automatic decode_event(input logic [1:0] act, input logic [7:0] id,
                                input logic [63:0] head, input logic [31:0] tail,
                                input logic chan);
        logic [7:0]  b [1:12];
        t_result     outs [$];
        t_result     r;
        logic [31:0] t;
        logic [4:0]  rx;
        int          k;
        for (k = 1; k <= 8; k++) b[k] = head[63 - 8 * (k - 1) -: 8];
        for (k = 9; k <= 12; k++) b[k] = tail[31 - 8 * (k - 9) -: 8];
        case (act)
            ACT_CONNECT: begin
                outs.push_back(control_item(PAD_NONE, MSG_LEDS));
                if (!mode_shadow) begin
                    outs.push_back(control_item(PAD_NONE, MSG_STATUS_MODE));
                    link_phase = PH_CONNECT;
                    link_kind  = KIND_NONE;
                end else begin
                    outs.push_back(control_item(PAD_NONE, MSG_STREAM_MODE));
                    link_phase = PH_DONE;
                    link_kind  = KIND_PRO;
                end
            end
            ACT_DISCONNECT: begin
                if (chan) outs.push_back(control_item(PAD_UNUSED, MSG_NONE));
            end
            ACT_REPORT: begin
                case (id)
                    // pro pad: 16-bit little-endian axes, offset removed
                    RID_PRO: begin
                        if (chan) begin
                            r            = '0;
                            r.pad_action = PAD_WRITE;
                            r.pad_kind   = KIND_PRO;
                            t = ({16'd0, b[2], b[1]} >> 3) - 32'd256;
                            r.stick_left_x = t[13:0];
                            t = ({16'd0, b[4], b[3]} >> 3) - 32'd256;
                            r.stick_right_x = t[13:0];
                            t = ({16'd0, b[6], b[5]} >> 3) - 32'd256;
                            r.stick_left_y = t[13:0];
                            t = ({16'd0, b[8], b[7]} >> 3) - 32'd256;
                            r.stick_right_y = t[13:0];
                            r.buttons = ~{b[9], b[10]};
                            outs.push_back(r);
                        end
                    end
                    // remote with extension: packed axes, triggers for the plain kind
                    RID_EXT: begin
                        if (chan && link_kind != KIND_NONE) begin
                            r            = '0;
                            r.pad_action = PAD_WRITE;
                            r.pad_kind   = link_kind;
                            t = {24'd0, b[3][5:0], 2'b00} - 32'd126;
                            r.stick_left_x = t[13:0];
                            rx = {b[3][7:6], b[4][7:6], b[5][7]};
                            t = {24'd0, rx, 3'b000} - 32'd124;
                            r.stick_right_x = t[13:0];
                            t = {24'd0, b[4][5:0], 2'b00} - 32'd126;
                            r.stick_left_y = t[13:0];
                            t = {24'd0, b[5][4:0], 3'b000} - 32'd124;
                            r.stick_right_y = t[13:0];
                            if (link_kind == KIND_PLAIN) begin
                                r.trigger_left  = {b[5][6:5], b[6][7:5], 3'b000};
                                r.trigger_right = {b[6][4:0], 3'b000};
                                r.trigger_valid = 1'b1;
                            end
                            r.buttons = ~{b[7][7:1], 1'b0, b[8]};
                            outs.push_back(r);
                        end
                    end
                    RID_BUTTONS: begin
                        if (link_phase == PH_CONNECT) begin
                            outs.push_back(control_item(PAD_NONE, MSG_STATUS_REQ));
                            link_phase = PH_EXT1;
                        end
                    end
                    RID_STATUS, RID_ACK: begin
                        if (b[3][1]) begin
                            if (id == RID_STATUS && link_phase == PH_EXT1) begin
                                outs.push_back(control_item(PAD_NONE, MSG_INIT_WRITE));
                                link_phase = PH_EXT2;
                            end else if (id == RID_ACK && link_phase == PH_EXT2) begin
                                outs.push_back(control_item(PAD_NONE, MSG_UNLOCK_WRITE));
                                link_phase = PH_SET_IDENT;
                            end else if (id == RID_ACK && link_phase == PH_SET_IDENT) begin
                                outs.push_back(control_item(PAD_NONE, MSG_IDENT_READ));
                                link_phase = PH_GET_IDENT;
                            end
                        end else if (!mode_shadow) begin
                            // extension gone: restart the handshake
                            link_kind  = KIND_NONE;
                            link_phase = PH_EXT1;
                            if (chan) outs.push_back(control_item(PAD_UNUSED, MSG_NONE));
                        end
                    end
                    RID_READ: begin
                        if (link_phase == PH_GET_IDENT) begin
                            if ({b[8], b[9], b[10], b[11]} == IDENT_WORD) begin
                                link_kind = (b[6] == 8'd0) ? KIND_PLAIN : KIND_PRO;
                                outs.push_back(control_item(PAD_NONE, MSG_STREAM_MODE));
                            end
                            link_phase = PH_DONE;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
        foreach (outs[k]) pending_results.push_back(outs[k]);
    endtask

    // offer one event, hold it until accepted, then predict its results
    task automatic send_event(input logic [1:0] act, input logic [7:0] id,
                              input logic [63:0] head, input logic [31:0] tail,
                              input logic chan);
        int gap;
        gap = sender_gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid            <= 1'b1;
        i_action           <= act;
        i_report_id        <= id;
        i_report_head      <= head;
        i_report_tail      <= tail;
        i_channel_assigned <= chan;
        do @(posedge i_clk); while (!o_ready);
        decode_event(act, id, head, tail, chan);
    endtask

    // stop offering and wait for every expected result plus the pipeline tail
    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    // write report_mode; only called while the block is idle
    task automatic write_report_mode(input logic mode);
        i_cfg_valid       <= 1'b1;
        i_cfg_report_mode <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        mode_shadow  = mode;
    endtask

    // report with the extension flag (byte 3 bit 1) forced
    function automatic logic [63:0] flagged_head(input logic flag);
        logic [63:0] h;
        h     = rand64();
        h[41] = flag;
        return h;
    endfunction

    // read-data report, optionally with the identity word and a plain-kind byte 6
    task automatic send_ident(input logic good, input logic plain);
        logic [63:0] h;
        logic [31:0] t;
        h = rand64();
        t = $urandom;
        if (good) begin
            h[7:0]  = IDENT_WORD[31:24];
            t[31:8] = IDENT_WORD[23:0];
        end
        if (plain) h[23:16] = 8'd0;
        else if (h[23:16] == 8'd0) h[23:16] = 8'h01;
        send_event(ACT_REPORT, RID_READ, h, t, 1'($urandom_range(0, 1)));
    endtask

    // connect, disconnect and unknown actions
    task automatic test_link_events();
        send_event(ACT_CONNECT, 8'h00, '0, '0, 1'b1);
        send_event(ACT_DISCONNECT, 8'hFF, '1, '1, 1'b1);
        send_event(ACT_DISCONNECT, 8'h00, '0, '0, 1'b0);
        send_event(2'd3, RID_PRO, rand64(), $urandom, 1'b1);
        wait_for_results();
    endtask

    // full extension handshake, decode extremes, reset by status and identity mismatch
    task automatic test_setup_handshake();
        send_event(ACT_REPORT, RID_BUTTONS, rand64(), $urandom, 1'b0);
        send_event(ACT_REPORT, RID_STATUS, flagged_head(1'b1), $urandom, 1'b1);
        send_event(ACT_REPORT, RID_ACK, flagged_head(1'b1), $urandom, 1'b1);
        send_event(ACT_REPORT, RID_ACK, flagged_head(1'b1), $urandom, 1'b0);
        send_ident(1'b1, 1'b1);
        send_event(ACT_REPORT, RID_EXT, '1, '1, 1'b1);
        send_event(ACT_REPORT, RID_EXT, '0, '0, 1'b1);
        send_event(ACT_REPORT, RID_PRO, '0, '0, 1'b1);
        send_event(ACT_REPORT, RID_PRO, '1, '1, 1'b1);
        send_event(ACT_REPORT, RID_PRO, '1, '1, 1'b0);
        send_event(ACT_REPORT, RID_STATUS, flagged_head(1'b0), $urandom, 1'b1);
        send_event(ACT_REPORT, RID_EXT, rand64(), $urandom, 1'b1);
        send_event(ACT_REPORT, RID_STATUS, flagged_head(1'b1), $urandom, 1'b1);
        send_event(ACT_REPORT, RID_ACK, flagged_head(1'b1), $urandom, 1'b1);
        send_event(ACT_REPORT, RID_ACK, flagged_head(1'b1), $urandom, 1'b1);
        send_ident(1'b0, 1'b1);
        send_event(ACT_REPORT, 8'h55, rand64(), $urandom, 1'b1);
        wait_for_results();
    endtask

    // pro pad mode: connect goes straight to streaming
    task automatic test_pro_mode();
        write_report_mode(1'b1);
        send_event(ACT_CONNECT, 8'h00, rand64(), $urandom, 1'b1);
        send_event(ACT_REPORT, RID_EXT, rand64(), $urandom, 1'b1);
        send_event(ACT_REPORT, RID_STATUS, flagged_head(1'b0), $urandom, 1'b1);
        wait_for_results();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        int k;
        sender_gaps_on = 1'b0;
        hold_request   = 1'b1;
        for (k = 0; k < 24; k++) send_event(ACT_REPORT, RID_PRO, rand64(), $urandom, 1'b1);
        sender_gaps_on = 1'b1;
        wait_for_results();
    endtask

    // one random scenario; sent counts events that the block acts on
    task automatic random_scenario(inout int sent);
        logic [7:0] step_ids [5];
        logic [7:0] id;
        int         pick;
        int         k;
        int         reports;
        step_ids = '{RID_BUTTONS, RID_STATUS, RID_ACK, RID_ACK, RID_READ};
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            // handshake with random content, now and then a step out of order
            send_event(ACT_CONNECT, 8'($urandom), rand64(), $urandom,
                       1'($urandom_range(0, 1)));
            for (k = 0; k < 5; k++) begin
                id = ($urandom_range(0, 9) == 0) ? step_ids[$urandom_range(0, 4)] : step_ids[k];
                if (id == RID_READ)
                    send_ident($urandom_range(0, 4) != 0, 1'($urandom_range(0, 1)));
                else
                    send_event(ACT_REPORT, id, flagged_head($urandom_range(0, 9) != 0),
                               $urandom, 1'($urandom_range(0, 1)));
            end
            reports = $urandom_range(2, 6);
            for (k = 0; k < reports; k++)
                send_event(ACT_REPORT, RID_EXT, rand64(), $urandom, $urandom_range(0, 7) != 0);
            sent += 6 + reports;
        end else if (pick < 70) begin
            id = $urandom_range(0, 1) ? RID_EXT : RID_PRO;
            send_event(ACT_REPORT, id, rand64(), $urandom, $urandom_range(0, 7) != 0);
            sent++;
        end else if (pick < 78) begin
            send_event(ACT_DISCONNECT, 8'($urandom), rand64(), $urandom,
                       1'($urandom_range(0, 1)));
            sent++;
        end else if (pick < 88) begin
            id = $urandom_range(0, 1) ? RID_STATUS : RID_ACK;
            send_event(ACT_REPORT, id, flagged_head(1'b0), $urandom, 1'($urandom_range(0, 1)));
            sent++;
        end else begin
            // noise: any action and report type
            send_event(2'($urandom_range(0, 3)), 8'($urandom), rand64(), $urandom,
                       1'($urandom_range(0, 1)));
        end
    endtask

    // random traffic over several mode settings and idle patterns
    task automatic test_random_traffic();
        int   phase_idx;
        int   sent;
        logic mode;
        for (phase_idx = 0; phase_idx < 8; phase_idx++) begin
            wait_for_results();
            if (phase_idx == 0) mode = 1'b0;
            else if (phase_idx == 1 || phase_idx == 5) mode = 1'b1;
            else mode = ($urandom_range(0, 3) == 0);
            write_report_mode(mode);
            sender_gaps_on  = (phase_idx % 4 != 2) && (phase_idx != 7);
            ready_stalls_on = (phase_idx % 4 != 3) && (phase_idx != 7);
            sent = 0;
            while (sent < 40) random_scenario(sent);
        end
        sender_gaps_on  = 1'b1;
        ready_stalls_on = 1'b1;
        wait_for_results();
    endtask

    // stimulus and final verdict
    initial begin
        i_rst_n            <= 1'b0;
        i_valid            <= 1'b0;
        i_action           <= '0;
        i_report_id        <= '0;
        i_report_head      <= '0;
        i_report_tail      <= '0;
        i_channel_assigned <= 1'b0;
        i_cfg_valid        <= 1'b0;
        i_cfg_report_mode  <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_link_events();
        test_setup_handshake();
        test_pro_mode();
        test_backpressure();
        test_random_traffic();
        wait_for_results();
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // receiver: random stalls per result, one long hold on request
    initial begin
        int stall;
        i_ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end
            stall = ready_stalls_on ? $urandom_range(0, 5) : 0;
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid && !hold_request);
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                $display("%0t unexpected result: expected none, actual message %0h pad %0h",
                         $time, o_message, o_pad_action);
            end else begin
                want = pending_results.pop_front();
                check_field("pad_action", 16'(want.pad_action), 16'(o_pad_action));
                check_field("pad_kind", 16'(want.pad_kind), 16'(o_pad_kind));
                check_field("stick_left_x", 16'(want.stick_left_x), 16'(o_stick_left_x));
                check_field("stick_right_x", 16'(want.stick_right_x), 16'(o_stick_right_x));
                check_field("stick_left_y", 16'(want.stick_left_y), 16'(o_stick_left_y));
                check_field("stick_right_y", 16'(want.stick_right_y), 16'(o_stick_right_y));
                check_field("buttons", want.buttons, o_buttons);
                check_field("trigger_left", 16'(want.trigger_left), 16'(o_trigger_left));
                check_field("trigger_right", 16'(want.trigger_right), 16'(o_trigger_right));
                check_field("trigger_valid", 16'(want.trigger_valid), 16'(o_trigger_valid));
                check_field("message", 16'(want.message), 16'(o_message));
                check_field("last", 16'(want.last), 16'(o_last));
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

[files.f]
design/gprd_pkg.sv
design/gprd_decode.sv
design/gamepad_report_decoder_unit.sv
design/gprd_checker.sv
sim/tb_gamepad_report_decoder_unit.sv
